// ===== hdl/gmec_pkg.sv =====
// Shared constants, types and operation codes for the greedy mesh element coloring block.
package gmec_pkg;

   // Sizing of the block.
   localparam int NODE_COUNT = 4096;
   localparam int MAX_COLORS = 32;
   localparam int MAX_NODES = 32;
   localparam int ELEM_W = 16;

   // Field widths fixed by the transaction formats.
   localparam int NODE_IN_W = 12;
   localparam int OUT_CLR_W = 6;

   // Derived widths. NODE_COUNT is a power of two, so the node number is a bit slice.
   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int LIST_AW = $clog2(MAX_NODES);
   localparam int LIST_W = NODE_W + MAX_COLORS;
   localparam int CLR_W = 7;

   // Operation codes of the request transaction.
   localparam logic OP_NODE = 1'b0;
   localparam logic OP_NEW_MESH = 1'b1;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_LOOKUP = 5'b00100,
      ST_PICK   = 5'b01000,
      ST_WRITE  = 5'b10000
   } gmec_state_type;

endpackage

// ===== hdl/gmec_if.sv =====
// Request and response channel interfaces of the greedy mesh element coloring block.
interface gmec_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [11:0] node_index;
   logic       last_node;

   modport source (output valid, output operation, output node_index, output last_node,
                   input ready);
   modport sink (input valid, input operation, input node_index, input last_node,
                 output ready);
endinterface

interface gmec_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] element_index;
   logic [5:0]  element_color;
   logic [5:0]  colors_used;
   logic        overflow;

   modport source (output valid, output element_index, output element_color,
                   output colors_used, output overflow, input ready);
   modport sink (input valid, input element_index, input element_color,
                 input colors_used, input overflow, output ready);
endinterface

// ===== hdl/greedy_mesh_element_coloring.sv =====
// Top level: greedy coloring of mesh elements streamed in as node indices.
// Each node transaction reads the mask RAM, then merges the mask and stores the node in
// the node list. The last node of an element adds a pick state, which waits for a free
// response register, and, unless the element overflows, a mask write-back over its nodes
// (one RAM write a cycle). Reset and each new-mesh transaction start a clearing pass over
// the mask RAM, during which no request is taken; response contents stay as they are.
module greedy_mesh_element_coloring import gmec_pkg::*; (
   input logic        clock,
   input logic        reset,
   gmec_req_if.sink   req_bus,
   gmec_rsp_if.source rsp_bus
);

   gmec_state_type state_ff, state_in;
   logic [NODE_W-1:0]     clear_addr_ff, clear_addr_in;
   logic [NODE_W-1:0]     node_ff, node_in;
   logic                  last_ff, last_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  too_many_ff, too_many_in;
   logic [MAX_COLORS-1:0] blocked_ff, blocked_in;
   logic [CLR_W-1:0]      total_ff, total_in;
   logic [ELEM_W-1:0]     elem_cnt_ff, elem_cnt_in;
   logic [MAX_COLORS-1:0] color_bit_ff, color_bit_in;
   logic [CNT_W-1:0]      wb_idx_ff, wb_idx_in;
   logic                  wb_pend_ff, wb_pend_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [OUT_CLR_W-1:0]  rsp_color_ff, rsp_color_in;
   logic [OUT_CLR_W-1:0]  rsp_used_ff, rsp_used_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  mask_wr_en;
   logic [NODE_W-1:0]     mask_wr_addr;
   logic [MAX_COLORS-1:0] mask_wr_data;
   logic [NODE_W-1:0]     mask_rd_addr;
   logic [MAX_COLORS-1:0] mask_rd_data;

   logic                  list_wr_en;
   logic [LIST_AW-1:0]    list_wr_addr;
   logic [LIST_W-1:0]     list_wr_data;
   logic [LIST_AW-1:0]    list_rd_addr;
   logic [LIST_W-1:0]     list_rd_data;

   logic                  pick_found;
   logic [MAX_COLORS-1:0] pick_bit;
   logic [CLR_W-1:0]      pick_color;
   logic                  pick_ovf;
   logic [CLR_W-1:0]      pick_total;
   logic                  req_accept;
   logic                  rsp_free;

   // Used-color mask per node.
   gmec_ram #(.WIDTH(MAX_COLORS), .DEPTH(NODE_COUNT)) u_mask_ram (
      .clock   (clock),
      .wr_en   (mask_wr_en),
      .wr_addr (mask_wr_addr),
      .wr_data (mask_wr_data),
      .rd_addr (mask_rd_addr),
      .rd_data (mask_rd_data)
   );

   // Nodes of the current element, each stored with the mask it had when read.
   gmec_ram #(.WIDTH(LIST_W), .DEPTH(MAX_NODES)) u_list_ram (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_addr (list_wr_addr),
      .wr_data (list_wr_data),
      .rd_addr (list_rd_addr),
      .rd_data (list_rd_data)
   );

   // Lowest free color of the accumulated blocked mask.
   gmec_color_unit u_color_unit (
      .blocked   (blocked_ff),
      .found     (pick_found),
      .color_bit (pick_bit),
      .color     (pick_color)
   );

   // Handshake terms.
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // Overflow and running color total for the element being finished.
   assign pick_ovf = too_many_ff || !pick_found;
   assign pick_total = (!pick_ovf && (pick_color > total_ff)) ? pick_color : total_ff;

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in = state_ff;
      clear_addr_in = clear_addr_ff;
      node_in = node_ff;
      last_in = last_ff;
      count_in = count_ff;
      too_many_in = too_many_ff;
      blocked_in = blocked_ff;
      total_in = total_ff;
      elem_cnt_in = elem_cnt_ff;
      color_bit_in = color_bit_ff;
      wb_idx_in = wb_idx_ff;
      wb_pend_in = wb_pend_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_index_in = rsp_index_ff;
      rsp_color_in = rsp_color_ff;
      rsp_used_in = rsp_used_ff;
      rsp_ovf_in = rsp_ovf_ff;

      mask_wr_en = 1'b0;
      mask_wr_addr = clear_addr_ff;
      mask_wr_data = '0;
      mask_rd_addr = req_bus.node_index[NODE_W-1:0];
      list_wr_en = 1'b0;
      list_wr_addr = count_ff[LIST_AW-1:0];
      list_wr_data = {node_ff, mask_rd_data};
      list_rd_addr = wb_idx_ff[LIST_AW-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep the mask RAM to zero, one node a cycle.
            mask_wr_en = 1'b1;
            clear_addr_in = clear_addr_ff + NODE_W'(1);
            if (clear_addr_ff == NODE_W'(NODE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_bus.operation == OP_NEW_MESH) begin
                  state_in = ST_CLEAR;
                  clear_addr_in = '0;
                  count_in = '0;
                  too_many_in = 1'b0;
                  blocked_in = '0;
                  total_in = '0;
                  elem_cnt_in = '0;
               end else begin
                  node_in = req_bus.node_index[NODE_W-1:0];
                  last_in = req_bus.last_node;
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            // Merge the node's mask and store the node while there is room.
            blocked_in = blocked_ff | mask_rd_data;
            if (count_ff < CNT_W'(MAX_NODES)) begin
               list_wr_en = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end else begin
               too_many_in = 1'b1;
            end
            state_in = last_ff ? ST_PICK : ST_IDLE;
         end
         ST_PICK: begin
            // Issue the response once the output register is free.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = elem_cnt_ff;
               rsp_ovf_in = pick_ovf;
               rsp_color_in = pick_ovf ? '0 : pick_color[OUT_CLR_W-1:0];
               rsp_used_in = pick_total[OUT_CLR_W-1:0];
               total_in = pick_total;
               elem_cnt_in = elem_cnt_ff + ELEM_W'(1);
               color_bit_in = pick_bit;
               wb_idx_in = '0;
               wb_pend_in = 1'b0;
               if (pick_ovf) begin
                  count_in = '0;
                  too_many_in = 1'b0;
                  blocked_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            // Read the node list one entry a cycle and write back the mask with the new color.
            mask_wr_en = wb_pend_ff;
            mask_wr_addr = list_rd_data[LIST_W-1 -: NODE_W];
            mask_wr_data = list_rd_data[MAX_COLORS-1:0] | color_bit_ff;
            if (wb_idx_ff < count_ff) begin
               wb_idx_in = wb_idx_ff + CNT_W'(1);
               wb_pend_in = 1'b1;
            end else begin
               wb_pend_in = 1'b0;
               count_in = '0;
               too_many_in = 1'b0;
               blocked_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clear_addr_in = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clear_addr_ff <= '0;
         count_ff <= '0;
         too_many_ff <= 1'b0;
         blocked_ff <= '0;
         total_ff <= '0;
         elem_cnt_ff <= '0;
         wb_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clear_addr_ff <= clear_addr_in;
         count_ff <= count_in;
         too_many_ff <= too_many_in;
         blocked_ff <= blocked_in;
         total_ff <= total_in;
         elem_cnt_ff <= elem_cnt_in;
         wb_pend_ff <= wb_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      node_ff <= node_in;
      last_ff <= last_in;
      color_bit_ff <= color_bit_in;
      wb_idx_ff <= wb_idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_color_ff <= rsp_color_in;
      rsp_used_ff <= rsp_used_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // Response channel.
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.element_index = rsp_index_ff;
   assign rsp_bus.element_color = rsp_color_ff;
   assign rsp_bus.colors_used = rsp_used_ff;
   assign rsp_bus.overflow = rsp_ovf_ff;

endmodule

// ===== hdl/gmec_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module gmec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/gmec_color_unit.sv =====
// Finds the lowest color whose bit is clear in the blocked-color mask.
module gmec_color_unit import gmec_pkg::*; (
   input  logic [MAX_COLORS-1:0] blocked,
   output logic                  found,
   output logic [MAX_COLORS-1:0] color_bit,
   output logic [CLR_W-1:0]      color
);

   logic [MAX_COLORS-1:0] free;

   // Isolate the lowest free bit with one two's-complement add.
   assign free = ~blocked;
   assign found = |free;
   assign color_bit = free & (~free + MAX_COLORS'(1));

   // Encode the one-hot bit; colors count from one.
   always_comb begin
      color = '0;
      for (int i = 0; i < MAX_COLORS; i++) begin
         if (color_bit[i]) begin
            color = color | CLR_W'(i + 1);
         end
      end
   end

endmodule

// ===== hdl/gmec_checker.sv =====
// Port-level assertions for the greedy mesh element coloring block, with its bind.
module gmec_checker import gmec_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [ELEM_W-1:0]    rsp_element_index,
   input logic [OUT_CLR_W-1:0] rsp_element_color,
   input logic [OUT_CLR_W-1:0] rsp_colors_used,
   input logic                 rsp_overflow
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element_index) &&
      $stable(rsp_element_color) && $stable(rsp_colors_used) && $stable(rsp_overflow))
      else $error("Stalled response transaction changed.");

   // An overflowed element carries no color.
   a_ovf_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_element_color == '0)
      else $error("Overflow response carries a nonzero color.");

   // A colored element never exceeds the running color count.
   a_color_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_overflow |->
      rsp_element_color != '0 && rsp_element_color <= rsp_colors_used)
      else $error("Assigned color outside the colors in use.");

   // Reset starts the mask clearing pass, so no request is taken right after it.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("Request ready directly after reset.");

   // Every request transaction takes the block out of idle, so ready drops once it is taken.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Request ready in the cycle after a transaction.");

endmodule

bind greedy_mesh_element_coloring gmec_checker u_gmec_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_element_index (rsp_bus.element_index),
   .rsp_element_color (rsp_bus.element_color),
   .rsp_colors_used   (rsp_bus.colors_used),
   .rsp_overflow      (rsp_bus.overflow)
);
